// ----- hw/rtl/ppbpe_pkg.sv -----
package ppbpe_pkg;

  // Storage geometry.
  localparam int unsigned PixAddrW = 12;             // 4096 pixels
  localparam int unsigned NeuronW  = 6;              // 64 neurons
  localparam int unsigned SynW     = 6;              // 64 synapses per neuron
  localparam int unsigned SynAddrW = NeuronW + SynW; // synapse table index
  localparam int unsigned SizeW    = 7;              // sizes and counts, 1..64
  localparam int unsigned MaxSize  = 64;
  localparam int unsigned PatW     = 64;
  localparam int unsigned Margin   = 10;
  // floor(v / 3) == (v * Recip3) >> Recip3Shift for every v up to 765.
  localparam int unsigned Recip3      = 683;
  localparam int unsigned Recip3Shift = 11;

  // Input function codes.
  typedef enum logic [1:0] {
    FUNC_PIX_WR = 2'd0,
    FUNC_SYN_WR = 2'd1,
    FUNC_CALC   = 2'd2,
    FUNC_NOP    = 2'd3
  } func_e;

  // Configuration register indexes.
  localparam logic [3:0] CFG_COLS  = 4'd0;
  localparam logic [3:0] CFG_ROWS  = 4'd1;
  localparam logic [3:0] CFG_COUNT = 4'd2;
  localparam logic [3:0] CFG_MODE  = 4'd3;

  typedef enum logic [2:0] {
    MODE_BLUE_HIGH     = 3'd0,
    MODE_RED_HIGH      = 3'd1,
    MODE_RED_NO_BLUE   = 3'd2,
    MODE_GREEN_NO_BLUE = 3'd3,
    MODE_GRAY          = 3'd4,
    MODE_GRAY_NO_BLUE  = 3'd5,
    MODE_SINGLE        = 3'd6
  } color_mode_e;

  // Operations handed from the front part to the back part.
  typedef enum logic [1:0] {
    OP_PIX_WR = 2'd0,
    OP_SYN_WR = 2'd1,
    OP_CALC   = 2'd2
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [PixAddrW-1:0] addr;  // pixel index, or {neuron, synapse}
    logic [31:0]         data;  // {red,green,blue} or {y_frac,x_frac}
  } cmd_t;

  // Configuration after saturation, as the back part uses it.
  typedef struct packed {
    logic [SizeW-1:0] cols;
    logic [SizeW-1:0] rows;
    logic [SizeW-1:0] count;
    color_mode_e      mode;
  } cfg_t;

  // Queue status seen by the back part.
  typedef struct packed {
    logic valid;
    cmd_t head;
  } q_out_t;

  function automatic logic [SizeW-1:0] sat_size(input logic [SizeW-1:0] v);
    logic [SizeW-1:0] r;
    if (v == '0) begin
      r = SizeW'(1);
    end else if (v > SizeW'(MaxSize)) begin
      r = SizeW'(MaxSize);
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

// ----- hw/rtl/ppbpe_front.sv -----
module ppbpe_front import ppbpe_pkg::*; (
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [PixAddrW-1:0] pixel_addr_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  input  logic [NeuronW-1:0]  neuron_i,
  input  logic [SynW-1:0]     synapse_i,
  input  logic [15:0]         x_frac_i,
  input  logic [15:0]         y_frac_i,
  input  logic                q_full_i,
  output logic                push_o,
  output cmd_t                cmd_o
);

  logic  accept;
  func_e func;

  assign func       = func_e'(func_i);
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i && !q_full_i;

  // The unused function code is taken and dropped here.
  always_comb begin
    cmd_o  = '{op: OP_CALC, addr: '0, data: '0};
    push_o = 1'b0;
    unique case (func)
      FUNC_PIX_WR: begin
        cmd_o.op   = OP_PIX_WR;
        cmd_o.addr = pixel_addr_i;
        cmd_o.data = {8'd0, red_i, green_i, blue_i};
        push_o     = accept;
      end
      FUNC_SYN_WR: begin
        cmd_o.op   = OP_SYN_WR;
        cmd_o.addr = {neuron_i, synapse_i};
        cmd_o.data = {y_frac_i, x_frac_i};
        push_o     = accept;
      end
      FUNC_CALC: begin
        cmd_o.op   = OP_CALC;
        cmd_o.addr = {neuron_i, SynW'(0)};
        push_o     = accept;
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

endmodule

// ----- hw/rtl/ppbpe_queue.sv -----
module ppbpe_queue import ppbpe_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  cmd_t   cmd_i,
  output logic   full_o,
  input  logic   pop_i,
  output q_out_t q_o
);

  cmd_t       entry_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = count_q == 2'd2;
  assign q_o.valid  = count_q != 2'd0;
  assign q_o.head   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

// ----- hw/rtl/ppbpe_back.sv -----
module ppbpe_back import ppbpe_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  q_out_t             q_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [PatW-1:0]    pattern_o,
  output logic [NeuronW-1:0] pattern_neuron_o
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_OUT
  } state_e;

  state_e             state_q;
  logic [SizeW-1:0]   iss_q;
  logic [NeuronW-1:0] neuron_q;
  logic [PatW-1:0]    pat_q, pat_d;
  logic [7:0]         first_q, prev_q;
  logic               out_valid_q;
  logic [PatW-1:0]    out_pat_q;
  logic [NeuronW-1:0] out_neuron_q;

  // Pipeline valid bits and tags, one per stage.
  logic            s1_v_q, s2_v_q, s3_v_q, s4_v_q, s5_v_q;
  logic [SynW-1:0] s1_idx_q, s2_idx_q, s3_idx_q, s4_idx_q, s5_idx_q;
  logic            s1_last_q, s2_last_q, s3_last_q, s4_last_q, s5_last_q;

  // Pipeline payload.
  logic [31:0]         syn_rd_q;
  logic [22:0]         xp_q, yp_q;
  logic [PixAddrW-1:0] pix_addr_q;
  logic [23:0]         pix_rd_q;
  logic [7:0]          intens_q;

  logic [31:0]         syn_mem [2**SynAddrW];
  logic [23:0]         pix_mem [2**PixAddrW];

  logic                issue;
  logic                issue_last;
  logic                calc_start;
  logic                out_load;
  logic                pix_we, syn_we;
  logic [SynAddrW-1:0] syn_ra;
  logic [SynW-1:0]     xcol, yrow;
  logic [12:0]         pix_addr_full;
  logic [8:0]          cur_plus;
  logic [8:0]          wrap_plus;

  function automatic logic [7:0] intensity(input logic [23:0] px, input color_mode_e mode);
    logic [7:0]  b, g, r;
    logic [9:0]  sum;
    logic [19:0] prod;
    logic [7:0]  v;
    b = px[7:0];
    g = px[15:8];
    r = px[23:16];
    sum = 10'(b) + 10'(g) + 10'(r);
    if (mode == MODE_GRAY_NO_BLUE) begin
      sum = 10'(g) + 10'(r);
    end
    prod = 20'(sum) * 20'(Recip3);
    unique case (mode)
      MODE_BLUE_HIGH:     v = r;
      MODE_RED_HIGH:      v = b;
      MODE_RED_NO_BLUE:   v = g;
      MODE_GREEN_NO_BLUE: v = r;
      MODE_GRAY,
      MODE_GRAY_NO_BLUE:  v = prod[Recip3Shift +: 8];
      MODE_SINGLE:        v = b;
      default:            v = 8'd0;
    endcase
    return v;
  endfunction

  assign pop_o      = (state_q == ST_IDLE) && q_i.valid;
  assign pix_we     = pop_o && (q_i.head.op == OP_PIX_WR);
  assign syn_we     = pop_o && (q_i.head.op == OP_SYN_WR);
  assign calc_start = pop_o && (q_i.head.op == OP_CALC);
  assign out_load   = (state_q == ST_OUT) && (!out_valid_q || !out_stall_i);
  assign issue      = (state_q == ST_RUN) && (iss_q < cfg_i.count);
  assign issue_last = iss_q == (cfg_i.count - SizeW'(1));
  assign syn_ra     = {neuron_q, iss_q[SynW-1:0]};

  // Scaled coordinates stay below the image size, so no clamp is needed.
  assign xcol          = xp_q[21:16];
  assign yrow          = yp_q[21:16];
  assign pix_addr_full = 13'(yrow) * 13'(cfg_i.cols) + 13'(xcol);

  // Pattern update as each intensity leaves the pipeline in synapse order.
  assign cur_plus  = 9'(intens_q) + 9'(Margin);
  assign wrap_plus = (s5_idx_q == '0) ? cur_plus : 9'(first_q) + 9'(Margin);
  always_comb begin
    pat_d = pat_q;
    if (calc_start) begin
      pat_d = '0;
    end else if (s5_v_q) begin
      if (s5_idx_q != '0) begin
        pat_d[s5_idx_q - SynW'(1)] = 9'(prev_q) > cur_plus;
      end
      if (s5_last_q) begin
        pat_d[s5_idx_q] = 9'(intens_q) > wrap_plus;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (syn_we) begin
      syn_mem[q_i.head.addr] <= q_i.head.data;
    end
    syn_rd_q <= syn_mem[syn_ra];
  end

  always_ff @(posedge clk_i) begin
    if (pix_we) begin
      pix_mem[q_i.head.addr] <= q_i.head.data[23:0];
    end
    pix_rd_q <= pix_mem[pix_addr_q];
  end

  always_ff @(posedge clk_i) begin
    xp_q       <= 23'(syn_rd_q[15:0]) * 23'(cfg_i.cols);
    yp_q       <= 23'(syn_rd_q[31:16]) * 23'(cfg_i.rows);
    pix_addr_q <= pix_addr_full[PixAddrW-1:0];
    intens_q   <= intensity(pix_rd_q, cfg_i.mode);
    s1_idx_q   <= iss_q[SynW-1:0];
    s1_last_q  <= issue_last;
    s2_idx_q   <= s1_idx_q;
    s2_last_q  <= s1_last_q;
    s3_idx_q   <= s2_idx_q;
    s3_last_q  <= s2_last_q;
    s4_idx_q   <= s3_idx_q;
    s4_last_q  <= s3_last_q;
    s5_idx_q   <= s4_idx_q;
    s5_last_q  <= s4_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_q        <= '0;
      neuron_q     <= '0;
      pat_q        <= '0;
      first_q      <= '0;
      prev_q       <= '0;
      s1_v_q       <= 1'b0;
      s2_v_q       <= 1'b0;
      s3_v_q       <= 1'b0;
      s4_v_q       <= 1'b0;
      s5_v_q       <= 1'b0;
      out_valid_q  <= 1'b0;
      out_pat_q    <= '0;
      out_neuron_q <= '0;
    end else begin
      s1_v_q <= issue;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s4_v_q <= s3_v_q;
      s5_v_q <= s4_v_q;
      pat_q  <= pat_d;
      if (issue) begin
        iss_q <= iss_q + SizeW'(1);
      end
      if (s5_v_q) begin
        prev_q <= intens_q;
        if (s5_idx_q == '0) begin
          first_q <= intens_q;
        end
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (calc_start) begin
            state_q  <= ST_RUN;
            iss_q    <= '0;
            neuron_q <= q_i.head.addr[PixAddrW-1 -: NeuronW];
          end
        end
        ST_RUN: begin
          if (s5_v_q && s5_last_q) begin
            state_q <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            out_pat_q    <= pat_q;
            out_neuron_q <= neuron_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pattern_o        = out_pat_q;
  assign pattern_neuron_o = out_neuron_q;

endmodule

// ----- hw/rtl/pixel_pair_bit_pattern_extractor_unit.sv -----
// Channel Dir Handshake                  Payload
// in      in  in_valid_i / in_stall_o    func, pixel_addr, colors, neuron, synapse, fracs
// out     out out_valid_o / out_stall_i  pattern, pattern_neuron
// cfg     in  cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A pixel or synapse write leaves the command queue while the back part is idle. A compute
// item holds the back part until its pattern is loaded into the output register; one synapse
// enters a five-stage pipeline each cycle, bounded by the single read port of the synapse
// table and the image. Reset clears the control state and loads the register defaults; both
// memories hold unknown contents until written, and there is no clearing pass.
// The two-entry queue lets writes be taken while a compute runs; a stalled result
// waits in the output register while the next queued commands proceed.
module pixel_pair_bit_pattern_extractor_unit import ppbpe_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // Input items.
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [1:0]          func_i,
  input  logic [PixAddrW-1:0] pixel_addr_i,
  input  logic [7:0]          blue_i,
  input  logic [7:0]          green_i,
  input  logic [7:0]          red_i,
  input  logic [NeuronW-1:0]  neuron_i,
  input  logic [SynW-1:0]     synapse_i,
  input  logic [15:0]         x_frac_i,
  input  logic [15:0]         y_frac_i,
  // Result items.
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [PatW-1:0]     pattern_o,
  output logic [NeuronW-1:0]  pattern_neuron_o,
  // Configuration writes.
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [3:0]          cfg_index_i,
  input  logic [SizeW-1:0]    cfg_data_i
);

  logic [SizeW-1:0] cols_q, rows_q, count_q;
  logic [2:0]       mode_q;
  cfg_t             cfg;

  logic   q_full, push, pop;
  cmd_t   cmd;
  q_out_t q_out;

  // Writes are always taken; the user only writes while the block is idle.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cols_q  <= SizeW'(32);
      rows_q  <= SizeW'(32);
      count_q <= SizeW'(64);
      mode_q  <= MODE_BLUE_HIGH;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_COLS:  cols_q  <= cfg_data_i;
        CFG_ROWS:  rows_q  <= cfg_data_i;
        CFG_COUNT: count_q <= cfg_data_i;
        CFG_MODE:  mode_q  <= cfg_data_i[2:0];
        default: begin
        end
      endcase
    end
  end

  // Zero or oversize size and count values saturate to the legal range.
  assign cfg.cols  = sat_size(cols_q);
  assign cfg.rows  = sat_size(rows_q);
  assign cfg.count = sat_size(count_q);
  assign cfg.mode  = color_mode_e'(mode_q);

  ppbpe_front u_front (
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .func_i       (func_i),
    .pixel_addr_i (pixel_addr_i),
    .blue_i       (blue_i),
    .green_i      (green_i),
    .red_i        (red_i),
    .neuron_i     (neuron_i),
    .synapse_i    (synapse_i),
    .x_frac_i     (x_frac_i),
    .y_frac_i     (y_frac_i),
    .q_full_i     (q_full),
    .push_o       (push),
    .cmd_o        (cmd)
  );

  ppbpe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (cmd),
    .full_o (q_full),
    .pop_i  (pop),
    .q_o    (q_out)
  );

  ppbpe_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .q_i              (q_out),
    .pop_o            (pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .pattern_o        (pattern_o),
    .pattern_neuron_o (pattern_neuron_o)
  );

endmodule
